// File: sv/mask_based_housekeeping_compressor_defines.svh
// Assertion macros used by the compressor's chunk assembler.
`ifndef MASK_BASED_HOUSEKEEPING_COMPRESSOR_DEFINES_SVH
`define MASK_BASED_HOUSEKEEPING_COMPRESSOR_DEFINES_SVH

// Checks a property on every rising clock edge while out of reset.
`define MBHC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mbhc assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define MBHC_ASSERT_IMP(lbl, cond, cons) \
  `MBHC_ASSERT(lbl, (cond) |-> (cons))

`endif

// File: sv/mbhc_pkg.sv
// Package with the shared types, constants and the counter code function.
package mbhc_pkg;

  localparam int unsigned VectorBitsDef    = 64;
  localparam int unsigned MaxRobustnessDef = 7;
  localparam int unsigned CodeW            = 16;
  localparam int unsigned ClenW            = 5;
  localparam int unsigned RunW             = 7;

  typedef struct packed {
    logic        func;
    logic [63:0] vector;
    logic [2:0]  robustness;
    logic        new_mask;
    logic        send_mask;
    logic        raw_input;
    logic        send_changes;
    logic        send_length;
  } in_item_t;

  typedef struct packed {
    logic [63:0] chunk;
    logic [6:0]  chunk_bits;
    logic        last;
    logic        error;
  } out_item_t;

  typedef struct packed {
    logic       term;
    logic       err;
    logic       sm;
    logic       raw;
    logic       sc;
    logic       sl;
    logic [2:0] r;
    logic       y_nz;
    logic       win_nz;
  } job_t;

  typedef struct packed {
    logic bit_v;
    logic bit_d;
    logic end_v;
    logic err;
  } ser_ev_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [ClenW-1:0] len;
  } count_code_t;

  // Counter code, left aligned. Values handled here never exceed 65, so the
  // long form always carries six bits.
  function automatic count_code_t count_code(logic [RunW-1:0] a);
    count_code_t      cc;
    logic [RunW-1:0]  v;
    v = a - RunW'(2);
    if (a <= RunW'(1)) begin
      cc.code = '0;
      cc.len  = ClenW'(1);
    end else if (a <= RunW'(33)) begin
      cc.code = {3'b110, v[4:0], 8'h00};
      cc.len  = ClenW'(8);
    end else begin
      cc.code = {3'b111, v[5:0], 7'h00};
      cc.len  = ClenW'(9);
    end
    return cc;
  endfunction

endpackage

// File: sv/mbhc_assembler.sv
// Packs the serial packet bits into chunks and holds the output register.
module mbhc_assembler
  import mbhc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ser_ev_t   ev_i,
  output logic      rdy_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic [63:0] acc_q, acc_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        ov_q, ov_d;
  out_item_t   out_q, out_d;

  assign rdy_o = !ov_q || !out_stall_i;

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    ov_d  = ov_q;
    out_d = out_q;
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
    if (rdy_o) begin
      if (ev_i.bit_v) begin
        // A full chunk is held back until it is known whether more follows.
        if (cnt_q == 7'd64) begin
          out_d = '{chunk: acc_q, chunk_bits: 7'd64, last: 1'b0, error: 1'b0};
          ov_d  = 1'b1;
          acc_d = {63'd0, ev_i.bit_d};
          cnt_d = 7'd1;
        end else begin
          acc_d = {acc_q[62:0], ev_i.bit_d};
          cnt_d = cnt_q + 7'd1;
        end
      end else if (ev_i.end_v) begin
        out_d.chunk      = ev_i.err ? 64'd0 : acc_q;
        out_d.chunk_bits = ev_i.err ? 7'd0 : cnt_q;
        out_d.last       = 1'b1;
        out_d.error      = ev_i.err;
        ov_d  = 1'b1;
        acc_d = '0;
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

`include "mask_based_housekeeping_compressor_defines.svh"

  `MBHC_ASSERT(a_cnt_range, cnt_q <= 7'd64)
  `MBHC_ASSERT_IMP(a_bits_nonzero, ov_q && !out_q.error, out_q.chunk_bits != 7'd0)
  `MBHC_ASSERT_IMP(a_err_shape, ov_q && out_q.error, out_q.last && out_q.chunk_bits == 7'd0)

endmodule

// File: sv/mbhc_serializer.sv
// Bit-serial sequencer that walks the packet fields one bit per cycle while the assembler is ready.
module mbhc_serializer
  import mbhc_pkg::*;
#(
  parameter int unsigned VECTOR_BITS = VectorBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  job_t                   job_i,
  input  logic [VECTOR_BITS-1:0] win_i,
  input  logic [VECTOR_BITS-1:0] mask_i,
  input  logic [VECTOR_BITS-1:0] vec_i,
  output logic                   busy_o,
  output ser_ev_t                ev_o,
  input  logic                   rdy_i
);

  localparam int unsigned PW = $clog2(VECTOR_BITS);
  localparam int unsigned SW = 5;

  localparam logic [SW-1:0] ST_IDLE = 5'd0;
  localparam logic [SW-1:0] ST_TERM = 5'd1;
  localparam logic [SW-1:0] ST_ERR  = 5'd2;
  localparam logic [SW-1:0] ST_H0   = 5'd3;
  localparam logic [SW-1:0] ST_H1   = 5'd4;
  localparam logic [SW-1:0] ST_H2   = 5'd5;
  localparam logic [SW-1:0] ST_H2S  = 5'd6;
  localparam logic [SW-1:0] ST_H3   = 5'd7;
  localparam logic [SW-1:0] ST_P2   = 5'd8;
  localparam logic [SW-1:0] ST_P2R  = 5'd9;
  localparam logic [SW-1:0] ST_P2E  = 5'd10;
  localparam logic [SW-1:0] ST_P3   = 5'd11;
  localparam logic [SW-1:0] ST_P3C  = 5'd12;
  localparam logic [SW-1:0] ST_P3V  = 5'd13;
  localparam logic [SW-1:0] ST_P3B  = 5'd14;
  localparam logic [SW-1:0] ST_P3M  = 5'd15;
  localparam logic [SW-1:0] ST_END  = 5'd16;
  localparam logic [SW-1:0] ST_CODE = 5'd17;
  localparam logic [SW-1:0] ST_RUNS = 5'd18;
  localparam logic [SW-1:0] ST_SEL  = 5'd19;

  logic [SW-1:0]          st_q, st_d, ret_q, ret_d, rret_q, rret_d;
  logic [CodeW-1:0]       code_q, code_d;
  logic [ClenW-1:0]       clen_q, clen_d;
  logic [VECTOR_BITS-1:0] src_q, src_d, sel_q, sel_d, a_q, a_d;
  logic [VECTOR_BITS-1:0] win_q, win_d, nm_q, nm_d, v_q, v_d;
  logic [PW-1:0]          pos_q, pos_d;
  logic [RunW-1:0]        run_q, run_d, run_n;
  job_t                   job_q, job_d;
  count_code_t            cc;
  logic                   dflag, lastpos;

  assign dflag   = !job_q.sm && !job_q.raw;
  assign lastpos = (pos_q == PW'(VECTOR_BITS - 1));
  assign run_n   = run_q + RunW'(1);
  assign busy_o  = (st_q != ST_IDLE);

  always_comb begin
    st_d   = st_q;
    ret_d  = ret_q;
    rret_d = rret_q;
    code_d = code_q;
    clen_d = clen_q;
    src_d  = src_q;
    sel_d  = sel_q;
    a_d    = a_q;
    win_d  = win_q;
    nm_d   = nm_q;
    v_d    = v_q;
    pos_d  = pos_q;
    run_d  = run_q;
    job_d  = job_q;
    ev_o   = '0;
    cc     = count_code(run_n);
    case (st_q)
      ST_IDLE: begin
        if (start_i) begin
          job_d = job_i;
          win_d = win_i;
          nm_d  = mask_i;
          v_d   = vec_i;
          if (job_i.term) begin
            st_d = ST_TERM;
          end else if (job_i.err) begin
            st_d = ST_ERR;
          end else begin
            st_d = ST_H0;
          end
        end
      end
      ST_TERM: begin
        cc     = count_code(RunW'(VECTOR_BITS + 1));
        code_d = cc.code;
        clen_d = cc.len;
        ret_d  = ST_END;
        st_d   = ST_CODE;
      end
      ST_ERR: begin
        ev_o.end_v = 1'b1;
        ev_o.err   = 1'b1;
        if (rdy_i) begin
          st_d = ST_IDLE;
        end
      end
      ST_H0: begin
        if (!job_q.sc) begin
          code_d = {6'b100000, 10'd0};
          clen_d = ClenW'(6);
          ret_d  = ST_P2;
          st_d   = ST_CODE;
        end else begin
          src_d  = win_q;
          pos_d  = '0;
          run_d  = '0;
          rret_d = ST_H1;
          st_d   = ST_RUNS;
        end
      end
      ST_H1: begin
        code_d = {2'b10, job_q.r, 11'd0};
        clen_d = ClenW'(5);
        ret_d  = ST_H2;
        st_d   = ST_CODE;
      end
      ST_H2: begin
        if (job_q.r != 3'd0 && job_q.win_nz) begin
          code_d = {job_q.y_nz, 15'd0};
          clen_d = ClenW'(1);
          ret_d  = job_q.y_nz ? ST_H2S : ST_H3;
          st_d   = ST_CODE;
        end else begin
          st_d = ST_H3;
        end
      end
      ST_H2S: begin
        a_d    = ~nm_q;
        sel_d  = win_q;
        pos_d  = '0;
        rret_d = ST_H3;
        st_d   = ST_SEL;
      end
      ST_H3: begin
        code_d = {dflag, 15'd0};
        clen_d = ClenW'(1);
        ret_d  = ST_P2;
        st_d   = ST_CODE;
      end
      ST_P2: begin
        if (dflag) begin
          st_d = ST_P3;
        end else begin
          code_d = {job_q.sm, 15'd0};
          clen_d = ClenW'(1);
          ret_d  = job_q.sm ? ST_P2R : ST_P3;
          st_d   = ST_CODE;
        end
      end
      ST_P2R: begin
        src_d  = nm_q ^ (nm_q << 1);
        pos_d  = '0;
        run_d  = '0;
        rret_d = ST_P2E;
        st_d   = ST_RUNS;
      end
      ST_P2E: begin
        code_d = {2'b10, 14'd0};
        clen_d = ClenW'(2);
        ret_d  = ST_P3;
        st_d   = ST_CODE;
      end
      ST_P3: begin
        if (dflag) begin
          a_d    = v_q;
          sel_d  = nm_q;
          pos_d  = '0;
          rret_d = ST_END;
          st_d   = ST_SEL;
        end else if (job_q.raw) begin
          code_d = {1'b1, job_q.sl, 14'd0};
          clen_d = ClenW'(2);
          ret_d  = job_q.sl ? ST_P3C : ST_P3V;
          st_d   = ST_CODE;
        end else begin
          code_d = '0;
          clen_d = ClenW'(1);
          ret_d  = ST_P3M;
          st_d   = ST_CODE;
        end
      end
      ST_P3C: begin
        cc     = count_code(RunW'(VECTOR_BITS));
        code_d = cc.code;
        clen_d = cc.len;
        ret_d  = ST_P3V;
        st_d   = ST_CODE;
      end
      ST_P3V: begin
        a_d    = v_q;
        sel_d  = '1;
        pos_d  = '0;
        rret_d = ST_P3B;
        st_d   = ST_SEL;
      end
      ST_P3B: begin
        code_d = {job_q.sm, 15'd0};
        clen_d = ClenW'(1);
        ret_d  = ST_END;
        st_d   = ST_CODE;
      end
      ST_P3M: begin
        a_d    = v_q;
        sel_d  = nm_q;
        pos_d  = '0;
        rret_d = ST_END;
        st_d   = ST_SEL;
      end
      ST_END: begin
        ev_o.end_v = 1'b1;
        if (rdy_i) begin
          st_d = ST_IDLE;
        end
      end
      ST_CODE: begin
        ev_o.bit_v = 1'b1;
        ev_o.bit_d = code_q[CodeW-1];
        if (rdy_i) begin
          code_d = code_q << 1;
          clen_d = clen_q - ClenW'(1);
          if (clen_q == ClenW'(1)) begin
            st_d = ret_q;
          end
        end
      end
      ST_RUNS: begin
        // One vector position per cycle; a one-bit hands its run to the coder.
        src_d = src_q >> 1;
        pos_d = pos_q + PW'(1);
        if (src_q[0]) begin
          code_d = cc.code;
          clen_d = cc.len;
          run_d  = '0;
          ret_d  = lastpos ? rret_q : ST_RUNS;
          st_d   = ST_CODE;
        end else begin
          run_d = run_n;
          if (lastpos) begin
            st_d = rret_q;
          end
        end
      end
      ST_SEL: begin
        if (sel_q[VECTOR_BITS-1]) begin
          ev_o.bit_v = 1'b1;
          ev_o.bit_d = a_q[VECTOR_BITS-1];
        end
        if (!sel_q[VECTOR_BITS-1] || rdy_i) begin
          a_d   = a_q << 1;
          sel_d = sel_q << 1;
          pos_d = pos_q + PW'(1);
          if (lastpos) begin
            st_d = rret_q;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q  <= ret_d;
    rret_q <= rret_d;
    code_q <= code_d;
    clen_q <= clen_d;
    src_q  <= src_d;
    sel_q  <= sel_d;
    a_q    <= a_d;
    win_q  <= win_d;
    nm_q   <= nm_d;
    v_q    <= v_d;
    pos_q  <= pos_d;
    run_q  <= run_d;
    job_q  <= job_d;
  end

endmodule

// File: sv/mask_based_housekeeping_compressor.sv
// Top level: mask and history state, packet sequencer and chunk packer.
// Each item is handled alone; the input stalls from acceptance until the last chunk is queued.
// One packet bit leaves the sequencer per cycle while the packer is not stalled; a compress
// item makes one to four run-length or selected-bit walks over the VECTOR_BITS positions.
// Reset clears the previous input, masks, change history and step count to zero.
module mask_based_housekeeping_compressor
  import mbhc_pkg::*;
#(
  parameter int unsigned VECTOR_BITS    = VectorBitsDef,
  parameter int unsigned MAX_ROBUSTNESS = MaxRobustnessDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic [VECTOR_BITS-1:0] prev_q, mask_q, build_q;
  logic [VECTOR_BITS-1:0] hist_q [MAX_ROBUSTNESS];
  logic [3:0]             step_q;

  logic [VECTOR_BITS-1:0] v, diff, nbuild, nmask, delta, win;
  logic [2:0]             r;
  logic                   first, err, accept, upd, busy;
  job_t                   job;
  ser_ev_t                ev;
  logic                   rdy;

  assign accept = in_valid_i && !busy;
  assign in_stall_o = busy;

  assign v     = in_data_i.vector[VECTOR_BITS-1:0];
  assign r     = (in_data_i.robustness > 3'(MAX_ROBUSTNESS)) ? 3'(MAX_ROBUSTNESS)
                                                             : in_data_i.robustness;
  assign first = (step_q == 4'd0);
  assign err   = !in_data_i.func && in_data_i.send_changes && first;
  assign upd   = accept && !in_data_i.func && !err;
  assign diff  = v ^ prev_q;

  always_comb begin
    nbuild = (!first && !in_data_i.new_mask) ? (diff | build_q) : '0;
    nmask  = first ? mask_q : (diff | (in_data_i.new_mask ? build_q : mask_q));
    delta  = nmask ^ mask_q;
    win    = delta;
    for (int i = 1; i <= MAX_ROBUSTNESS; i++) begin
      if (3'(i) <= r) begin
        win = win | hist_q[i-1];
      end
    end
  end

  always_comb begin
    job.term   = in_data_i.func;
    job.err    = err;
    job.sm     = in_data_i.send_mask;
    job.raw    = in_data_i.raw_input;
    job.sc     = in_data_i.send_changes;
    job.sl     = in_data_i.send_length;
    job.r      = r;
    job.y_nz   = |(~nmask & win);
    job.win_nz = |win;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      mask_q  <= '0;
      build_q <= '0;
      step_q  <= '0;
      for (int i = 0; i < MAX_ROBUSTNESS; i++) begin
        hist_q[i] <= '0;
      end
    end else if (upd) begin
      prev_q  <= v;
      mask_q  <= nmask;
      build_q <= nbuild;
      if (step_q < 4'd8) begin
        step_q <= step_q + 4'd1;
      end
      hist_q[0] <= delta;
      for (int i = 1; i < MAX_ROBUSTNESS; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  mbhc_serializer #(
    .VECTOR_BITS(VECTOR_BITS)
  ) u_ser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .job_i  (job),
    .win_i  (win),
    .mask_i (nmask),
    .vec_i  (v),
    .busy_o (busy),
    .ev_o   (ev),
    .rdy_i  (rdy)
  );

  mbhc_assembler u_asm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ev_i       (ev),
    .rdy_o      (rdy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
